// ===== rtl/core/rolling_key_byte_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// Rolling key byte cipher assertion macros
// Shared concurrent assertion forms for the cipher blocks
// ----------------------------------------------------------------------------
`ifndef ROLLING_KEY_BYTE_CIPHER_MACROS_SVH
`define ROLLING_KEY_BYTE_CIPHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RKBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RKBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rkbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rolling key byte cipher package
// Opcodes and fixed field widths shared by the cipher modules
// ----------------------------------------------------------------------------
package rkbc_pkg;

  localparam int OPCODE_W   = 2;
  localparam int KEY_IDX_W  = 6;
  localparam int BYTE_W     = 8;
  localparam int KEY_LEN_W  = 7;
  // wide enough for key positions, indexes and lengths up to 256
  localparam int IDX_EXT_W  = 9;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KEY_LEN_W-1:0] key_len_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_ENCRYPT  = 2'd1,
    OP_RESTART  = 2'd2,
    OP_IGNORE   = 2'd3
  } opcode_t;

endpackage

// ===== rtl/core/rkbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data
// ----------------------------------------------------------------------------
module rkbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rkbc_sched.sv =====
// ----------------------------------------------------------------------------
// Rolling key scheduler
// Holds the key length, key position, threshold and offset of the stream
// ----------------------------------------------------------------------------
module rkbc_sched #(
  parameter int MAX_KEY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       key_length_we,
  input  rkbc_pkg::key_len_t         key_length,
  input  logic                       step,
  input  rkbc_pkg::opcode_t          opcode,
  output logic [$clog2(MAX_KEY)-1:0] position,
  output rkbc_pkg::byte_t            offset
);

  import rkbc_pkg::*;

  localparam int PW = $clog2(MAX_KEY);

  key_len_t             key_len;
  key_len_t             threshold;
  key_len_t             threshold_next;
  logic [PW-1:0]        position_next;
  byte_t                offset_next;
  key_len_t             eff_len;
  logic [IDX_EXT_W-1:0] len_ext;
  logic [IDX_EXT_W-1:0] pos_inc;
  logic [IDX_EXT_W-1:0] thr_ext;
  key_len_t             thr_dec;
  logic                 restart;

  // effective key length: zero reads as one, clipped to the store size
  always_comb begin
    len_ext = IDX_EXT_W'(key_len);
    if (key_len == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (len_ext > IDX_EXT_W'(MAX_KEY)) begin
      eff_len = KEY_LEN_W'(MAX_KEY);
    end else begin
      eff_len = key_len;
    end
  end

  // key length register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= KEY_LEN_W'(1);
    end else if (key_length_we) begin
      key_len <= key_length;
    end
  end

  // position advance and threshold rollover
  always_comb begin
    pos_inc        = IDX_EXT_W'(position) + IDX_EXT_W'(1);
    thr_ext        = IDX_EXT_W'(threshold);
    thr_dec        = threshold - KEY_LEN_W'(1);
    restart        = 1'b0;
    position_next  = position;
    offset_next    = offset;
    threshold_next = threshold;
    if (step) begin
      case (opcode)
        OP_LOAD_KEY: restart = 1'b1;
        OP_RESTART:  restart = 1'b1;
        OP_ENCRYPT: begin
          if (pos_inc >= thr_ext) begin
            position_next  = '0;
            offset_next    = offset + BYTE_W'(eff_len);
            threshold_next = (thr_dec == '0) ? eff_len : thr_dec;
          end else begin
            position_next = pos_inc[PW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // stream state; a restart takes the length in force after this edge
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      offset    <= '0;
      threshold <= KEY_LEN_W'(1);
    end else if (key_length_we) begin
      position  <= '0;
      offset    <= '0;
      if (key_length == '0) begin
        threshold <= KEY_LEN_W'(1);
      end else if (IDX_EXT_W'(key_length) > IDX_EXT_W'(MAX_KEY)) begin
        threshold <= KEY_LEN_W'(MAX_KEY);
      end else begin
        threshold <= key_length;
      end
    end else if (restart) begin
      position  <= '0;
      offset    <= '0;
      threshold <= eff_len;
    end else begin
      position  <= position_next;
      offset    <= offset_next;
      threshold <= threshold_next;
    end
  end

  `include "rolling_key_byte_cipher_macros.svh"

  `RKBC_ASSERT_NOW(a_thr_nonzero, clk, rst, 1'b1, threshold != '0, "threshold is zero")
  `RKBC_ASSERT_NOW(a_pos_below_thr, clk, rst, 1'b1, IDX_EXT_W'(position) < thr_ext, "position past threshold")
  `RKBC_ASSERT_NEXT(a_restart_clears, clk, rst, key_length_we || restart, position == '0 && offset == '0, "restart left stream state")

endmodule

// ===== rtl/core/rolling_key_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// Rolling key byte cipher
// Additive byte cipher whose key offset rolls forward over the stream
// ----------------------------------------------------------------------------
// One input transfer is taken every clock while the output side keeps up:
// key loads, restarts and encrypts all issue back to back. An encrypted byte
// passes through the key store read register and then the output register:
// the transfer edge loads the read register, and the sum is loaded into the
// output register once that is free or being taken. The input stalls only
// while both stages hold a byte and the output is not taken. Key loads,
// restarts and key_length writes restart the stream. The user must write
// key_length only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rolling_key_byte_cipher #(
  parameter int MAX_KEY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_length_we,
  input  rkbc_pkg::key_len_t key_length,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [5:0]         key_index,
  input  rkbc_pkg::byte_t    data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output rkbc_pkg::byte_t    cipher_byte
);

  import rkbc_pkg::*;

  localparam int PW = $clog2(MAX_KEY);

  opcode_t              op;
  logic                 in_xfer;
  logic                 enc_xfer;
  logic                 key_we;
  logic [IDX_EXT_W-1:0] key_idx_ext;
  logic [PW-1:0]        position;
  byte_t                offset;
  byte_t                key_rdata;
  logic                 s1_valid;
  byte_t                s1_data;
  byte_t                s1_offset;
  logic                 s1_move;

  // input decode
  always_comb begin
    op          = opcode_t'(opcode);
    in_xfer     = in_valid && in_ready;
    enc_xfer    = in_xfer && (op == OP_ENCRYPT);
    key_idx_ext = IDX_EXT_W'(key_index);
    key_we      = in_xfer && (op == OP_LOAD_KEY) && (key_idx_ext < IDX_EXT_W'(MAX_KEY));
    s1_move     = s1_valid && (!out_valid || out_ready);
    in_ready    = !(s1_valid && out_valid && !out_ready);
  end

  // stream state
  rkbc_sched #(
    .MAX_KEY(MAX_KEY)
  ) u_sched (
    .clk          (clk),
    .rst          (rst),
    .key_length_we(key_length_we),
    .key_length   (key_length),
    .step         (in_xfer),
    .opcode       (op),
    .position     (position),
    .offset       (offset)
  );

  // key store
  rkbc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_KEY)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_idx_ext[PW-1:0]),
    .wdata(data_byte),
    .re   (enc_xfer),
    .raddr(position),
    .rdata(key_rdata)
  );

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (enc_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (enc_xfer) begin
      s1_data   <= data_byte;
      s1_offset <= offset;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // cipher byte: plain plus key byte plus offset, mod 256
  always_ff @(posedge clk) begin
    if (s1_move) begin
      cipher_byte <= s1_data + key_rdata + s1_offset;
    end
  end

  `include "rolling_key_byte_cipher_macros.svh"

  `RKBC_ASSERT_NOW(a_stall_blocks_input, clk, rst, s1_valid && out_valid && !out_ready,
                   !in_ready, "input taken with both stages full")
  `RKBC_ASSERT_NEXT(a_encrypt_fills_s1, clk, rst, enc_xfer, s1_valid, "encrypt transfer lost")
  `RKBC_ASSERT_NEXT(a_no_spurious_s1, clk, rst, in_xfer && op != OP_ENCRYPT && !s1_valid,
                    !s1_valid, "read stage filled without encrypt")

endmodule
